### rtl/searchable_stack_core_defines.svh
// ------------------------------------------------------------------------
// searchable stack assertion macros
// shared property templates for the searchable stack checks
// ------------------------------------------------------------------------
`ifndef SEARCHABLE_STACK_CORE_DEFINES_SVH
`define SEARCHABLE_STACK_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SSC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("searchable_stack_core: check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SSC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("searchable_stack_core: check failed");

`endif

### rtl/ss_pkg.sv
// ------------------------------------------------------------------------
// ss_pkg
// shared constants, codes, command and result types of the searchable stack
// ------------------------------------------------------------------------
package ss_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam int WORD_W   = 32;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int FIDX_W   = 4;
	localparam int FILL_W   = 5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FIND = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_SWAP = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic                     find;
		logic                     swap;
		logic signed [WORD_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [WORD_W-1:0] popped_value;
		logic                     found;
		logic [FIDX_W-1:0]        found_index;
		logic signed [WORD_W-1:0] top_value;
		logic                     top_valid;
		logic [FILL_W-1:0]        fill_count;
	} res_t;

	// position truncated or zero-extended to the reported index width
	function automatic logic [FIDX_W-1:0] to_fidx(input logic [IDX_W-1:0] pos);
		logic [IDX_W+FIDX_W-1:0] wide;
		wide = {{FIDX_W{1'b0}}, pos};
		return wide[FIDX_W-1:0];
	endfunction

	// count truncated or zero-extended to the reported fill width
	function automatic logic [FILL_W-1:0] to_fill(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+FILL_W-1:0] wide;
		wide = {{FILL_W{1'b0}}, cnt};
		return wide[FILL_W-1:0];
	endfunction

	localparam logic [FILL_W-1:0] FULL_FILL = to_fill(CNT_W'(STACK_DEPTH));

endpackage

### rtl/ss_front.sv
// ------------------------------------------------------------------------
// ss_front
// accepts input transactions and decodes the operation into a command
// ------------------------------------------------------------------------
module ss_front (
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ss_pkg::FUNC_W-1:0]        func,
	input  logic signed [ss_pkg::WORD_W-1:0] value,
	output ss_pkg::cmd_t                     wr_cmd,
	output logic                             wr_valid,
	input  logic                             wr_ready
);
	import ss_pkg::*;

	always_comb begin
		wr_cmd       = '0;
		wr_cmd.value = value;
		case (func)
			FUNC_PUSH: begin
				wr_cmd.push = 1'b1;
			end
			FUNC_POP: begin
				wr_cmd.pop = 1'b1;
			end
			FUNC_FIND: begin
				wr_cmd.find = 1'b1;
			end
			FUNC_SWAP: begin
				wr_cmd.swap = 1'b1;
			end
			default: begin
				wr_cmd.find = 1'b0;
			end
		endcase
	end

	assign wr_valid = in_valid;
	assign in_ready = wr_ready;

endmodule

### rtl/ss_queue.sv
// ------------------------------------------------------------------------
// ss_queue
// short command queue between the front and the back
// ------------------------------------------------------------------------
module ss_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  ss_pkg::cmd_t wr_cmd,
	input  logic         wr_valid,
	output logic         wr_ready,
	output ss_pkg::cmd_t rd_cmd,
	output logic         rd_valid,
	input  logic         rd_ready
);
	import ss_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

### rtl/ss_back.sv
// ------------------------------------------------------------------------
// ss_back
// stack storage, parallel key search and result register
// ------------------------------------------------------------------------
module ss_back (
	input  logic         clk,
	input  logic         arst_n,
	input  ss_pkg::cmd_t q_cmd,
	input  logic         q_valid,
	output logic         q_ready,
	output ss_pkg::res_t res,
	output logic         res_valid,
	input  logic         res_ready
);
	import ss_pkg::*;

	localparam logic ST_EXEC  = 1'b0;
	localparam logic ST_APPLY = 1'b1;

	// entry 0 is the top of the stack, deeper entries sit at higher slots
	logic signed [WORD_W-1:0] entries_q [STACK_DEPTH];
	logic [CNT_W-1:0]         count_q;
	logic                     state_q;
	logic [STACK_DEPTH-1:0]   match_s1;
	logic                     swap_s1;
	res_t                     res_q;
	logic                     res_valid_q;

	logic                     out_free;
	logic                     is_search;
	logic                     take;
	logic                     do_exec;
	logic                     do_search;
	logic                     do_apply;
	logic                     done;
	logic                     full;
	logic [STACK_DEPTH-1:0]   hit;
	logic                     pick_found;
	logic [IDX_W-1:0]         pick_k;
	logic [CNT_W-1:0]         top_pos;
	logic [IDX_W-1:0]         pos;
	logic signed [WORD_W-1:0] pick_word;
	logic [CNT_W-1:0]         cnt_next;
	res_t                     res_d;

	assign out_free  = !res_valid_q || res_ready;
	assign is_search = q_cmd.find || q_cmd.swap;
	assign take      = q_valid && (state_q == ST_EXEC) && (is_search || out_free);
	assign q_ready   = take;
	assign do_exec   = take && !is_search;
	assign do_search = take && is_search;
	assign do_apply  = (state_q == ST_APPLY) && out_free;
	assign done      = do_exec || do_apply;
	assign full      = (count_q == CNT_W'(STACK_DEPTH));

	// compare all live entries against the key
	always_comb begin
		for (int k = 0; k < STACK_DEPTH; k++) begin
			hit[k] = (CNT_W'(k) < count_q) && (entries_q[k] == q_cmd.value);
		end
	end

	// deepest match from the top is the lowest position from the bottom
	always_comb begin
		pick_found = 1'b0;
		pick_k     = '0;
		for (int k = 0; k < STACK_DEPTH; k++) begin
			if (match_s1[k]) begin
				pick_found = 1'b1;
				pick_k     = IDX_W'(k);
			end
		end
	end

	assign top_pos   = count_q - CNT_W'(1);
	assign pos       = top_pos[IDX_W-1:0] - pick_k;
	assign pick_word = entries_q[pick_k];

	always_comb begin
		res_d              = '0;
		res_d.status       = STATUS_OK;
		cnt_next           = count_q;
		res_d.top_value    = (count_q != '0) ? entries_q[0] : '0;
		if (state_q == ST_APPLY) begin
			if (pick_found) begin
				res_d.found       = 1'b1;
				res_d.found_index = to_fidx(pos);
				if (swap_s1) begin
					res_d.top_value = pick_word;
				end
			end else begin
				res_d.status = STATUS_NOTFOUND;
			end
		end else if (q_cmd.push) begin
			if (full) begin
				res_d.status = STATUS_FULL;
			end else begin
				res_d.top_value = q_cmd.value;
				cnt_next        = count_q + CNT_W'(1);
			end
		end else begin
			if (count_q == '0) begin
				res_d.status = STATUS_EMPTY;
			end else begin
				res_d.popped_value = entries_q[0];
				res_d.top_value    = (count_q > CNT_W'(1)) ? entries_q[1] : '0;
				cnt_next           = count_q - CNT_W'(1);
			end
		end
		res_d.top_valid  = (cnt_next != '0);
		res_d.fill_count = to_fill(cnt_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EXEC;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (do_search) begin
				state_q <= ST_APPLY;
			end else if (do_apply) begin
				state_q <= ST_EXEC;
			end
			if (done) begin
				count_q     <= cnt_next;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_search) begin
			match_s1 <= hit;
			swap_s1  <= q_cmd.swap;
		end
		if (done) begin
			res_q <= res_d;
		end
		if (do_exec && q_cmd.push && !full) begin
			entries_q[0] <= q_cmd.value;
			for (int k = 1; k < STACK_DEPTH; k++) begin
				entries_q[k] <= entries_q[k-1];
			end
		end
		if (do_exec && q_cmd.pop && (count_q != '0)) begin
			for (int k = 0; k < STACK_DEPTH - 1; k++) begin
				entries_q[k] <= entries_q[k+1];
			end
		end
		if (do_apply && swap_s1 && pick_found) begin
			// a match at the top leaves the contents as they are
			if (pick_k != '0) begin
				entries_q[pick_k] <= entries_q[0];
			end
			entries_q[0]      <= pick_word;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

### rtl/searchable_stack_core.sv
// ------------------------------------------------------------------------
// searchable_stack_core
// lifo stack of signed words with push, pop, find and swap-with-top
// ------------------------------------------------------------------------
// Each input transaction carries one operation and yields exactly one
// result transaction. Push and pop pass through the execution unit in its
// exec state; find and swap also pass through its apply state: the exec state
// registers the compare of the key against every live entry, the apply state
// picks the lowest matching position and, for swap, updates the stack. Results
// leave from an output register, and a two-entry command queue sits between
// the input decode and the execution unit, so input transactions keep being
// taken while a result waits, until the queue is full. No clearing pass
// follows reset; only entries below the fill count are ever read.
`include "searchable_stack_core_defines.svh"

module searchable_stack_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ss_pkg::FUNC_W-1:0]          func,
	input  logic signed [ss_pkg::WORD_W-1:0]   value,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ss_pkg::STATUS_W-1:0]        status,
	output logic signed [ss_pkg::WORD_W-1:0]   popped_value,
	output logic                               found,
	output logic [ss_pkg::FIDX_W-1:0]          found_index,
	output logic signed [ss_pkg::WORD_W-1:0]   top_value,
	output logic                               top_valid,
	output logic [ss_pkg::FILL_W-1:0]          fill_count
);
	import ss_pkg::*;

	// decoded command from the front into the queue
	cmd_t wr_cmd;
	logic wr_valid;
	logic wr_ready;

	// command from the queue into the execution unit
	cmd_t q_cmd;
	logic q_valid;
	logic q_ready;

	// registered result transaction
	res_t res;

	// front: takes input transactions whenever the queue has room
	ss_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.value    (value),
		.wr_cmd   (wr_cmd),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready)
	);

	// queue: decouples input stalls from execution stalls
	ss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (wr_cmd),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.rd_cmd   (q_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	// back: stack storage, search and result register
	ss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_cmd     (q_cmd),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.res       (res),
		.res_valid (out_valid),
		.res_ready (out_ready)
	);

	// result fields onto their ports
	assign status       = res.status;
	assign popped_value = res.popped_value;
	assign found        = res.found;
	assign found_index  = res.found_index;
	assign top_value    = res.top_value;
	assign top_valid    = res.top_valid;
	assign fill_count   = res.fill_count;

	// a match is always reported with an ok status
	`SSC_ASSERT_IMP(a_found_ok, out_valid && found, status == STATUS_OK)
	// top_valid tracks a nonzero fill count
	`SSC_ASSERT_IMP(a_top_valid, out_valid, top_valid == (fill_count != '0))
	// a full report only comes from a stack at capacity
	`SSC_ASSERT_IMP(a_full_cnt, out_valid && status == STATUS_FULL, fill_count == FULL_FILL)
	// a queued command is held until the execution unit takes it
	`SSC_ASSERT_NXT(a_queue_hold, q_valid && !q_ready, q_valid)

endmodule
